// ===== src/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [15:0] UNIT_TICKS_RST  = 16'd100;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S1   = 4'd1,
    PH_S2   = 4'd2,
    PH_P1   = 4'd3,
    PH_P2   = 4'd4,
    PH_WS   = 4'd5,
    PH_WH   = 4'd6,
    PH_WL   = 4'd7,
    PH_A1   = 4'd8,
    PH_A2   = 4'd9,
    PH_AP   = 4'd10,
    PH_RL   = 4'd11,
    PH_RH   = 4'd12,
    PH_K1   = 4'd13,
    PH_K2   = 4'd14
  } phase_t;

  typedef enum logic {
    REG_UNIT_TICKS  = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       cmd_valid;
    op_t        op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [TIMER_WIDTH-1:0] unit_ticks;
    logic [15:0]            ack_timeout;
  } cfg_t;

  function automatic logic [2:0] phase_units(phase_t ph);
    logic [2:0] u;
    unique case (ph)
      PH_S1, PH_S2, PH_P1, PH_P2:        u = 3'd4;
      PH_WS, PH_WH, PH_WL, PH_RL,
      PH_K1, PH_K2:                      u = 3'd2;
      PH_A1, PH_A2, PH_RH:               u = 3'd1;
      default:                           u = 3'd0;
    endcase
    return u;
  endfunction

endpackage

// ===== src/i2cmbe_front.sv =====
module i2cmbe_front
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd_valid,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_tx_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_in,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  item_t             cls;

  assign in_stall = (count_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    cls.cmd_valid = in_cmd_valid;
    cls.op        = op_t'(in_mode);
    cls.tx_byte   = in_tx_byte;
    cls.send_ack  = in_send_ack;
    cls.sda_in    = in_sda_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue over depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == QCNT_W'(QDEPTH)) |-> !push)
    else $error("push into full queue");

endmodule

// ===== src/i2cmbe_back.sv =====
module i2cmbe_back
  import i2cmbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_error
);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [TIMER_WIDTH-1:0] wait_r, wait_nxt;
  logic [2:0]             unit_r, unit_nxt;
  logic [15:0]            poll_r, poll_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   ackc_r, ackc_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   err_r, err_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   done;
  logic                   step;
  logic                   do_enter;
  logic [TIMER_WIDTH-1:0] unit_len, wait_inc;
  logic [2:0]             unit_inc;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_sh;

  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_busy_r, out_done_r, out_err_r;
  logic [7:0] out_rx_r;

  assign step  = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      wait_r  <= '0;
      unit_r  <= '0;
      poll_r  <= '0;
      shift_r <= '0;
      ackc_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      err_r   <= 1'b0;
      rx_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      wait_r  <= wait_nxt;
      unit_r  <= unit_nxt;
      poll_r  <= poll_nxt;
      shift_r <= shift_nxt;
      ackc_r  <= ackc_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      err_r   <= err_nxt;
      rx_r    <= rx_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    wait_nxt  = wait_r;
    unit_nxt  = unit_r;
    poll_nxt  = poll_r;
    shift_nxt = shift_r;
    ackc_nxt  = ackc_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    err_nxt   = err_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    do_enter  = 1'b0;
    unit_len  = (cfg.unit_ticks == '0) ? TIMER_WIDTH'(1) : cfg.unit_ticks;
    wait_inc  = wait_r + 1'b1;
    unit_inc  = unit_r + 1'b1;
    bit_inc   = bit_r + 1'b1;
    shift_sh  = {shift_r[6:0], 1'b0};

    priority if (phase_r == PH_IDLE) begin
      if (q_item.cmd_valid) begin
        bit_nxt  = '0;
        do_enter = 1'b1;
        unique case (q_item.op)
          OP_START: begin
            phase_nxt = PH_S1; scl_nxt = 1'b1; sda_nxt = 1'b1;
          end
          OP_STOP: begin
            phase_nxt = PH_P1; scl_nxt = 1'b0; sda_nxt = 1'b0;
          end
          OP_WRITE: begin
            err_nxt   = 1'b0;
            shift_nxt = q_item.tx_byte;
            phase_nxt = PH_WS; scl_nxt = 1'b0; sda_nxt = q_item.tx_byte[7];
          end
          OP_READ: begin
            shift_nxt = '0;
            ackc_nxt  = q_item.send_ack;
            phase_nxt = PH_RL; scl_nxt = 1'b0; sda_nxt = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (phase_r == PH_AP) begin
      priority if (!q_item.sda_in) begin
        phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b1;
        do_enter  = 1'b1;
        done      = 1'b1;
      end else if (poll_r >= cfg.ack_timeout) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_P1; scl_nxt = 1'b0; sda_nxt = 1'b0;
        do_enter  = 1'b1;
      end else begin
        poll_nxt = poll_r + 1'b1;
      end
    end else begin
      wait_nxt = wait_inc;
      if (wait_inc >= unit_len) begin
        wait_nxt = '0;
        unit_nxt = unit_inc;
        if (unit_inc >= phase_units(phase_r)) begin
          do_enter = 1'b1;
          unique case (phase_r)
            PH_S1: begin phase_nxt = PH_S2; scl_nxt = 1'b1; sda_nxt = 1'b0; end
            PH_S2: begin
              phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
            end
            PH_P1: begin phase_nxt = PH_P2; scl_nxt = 1'b1; sda_nxt = 1'b1; end
            PH_P2: begin
              phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
            end
            PH_WS: begin phase_nxt = PH_WH; scl_nxt = 1'b1; end
            PH_WH: begin phase_nxt = PH_WL; scl_nxt = 1'b0; end
            PH_WL: begin
              shift_nxt = shift_sh;
              bit_nxt   = bit_inc;
              scl_nxt   = 1'b0;
              if (bit_inc >= BITS_PER_BYTE) begin
                phase_nxt = PH_A1; sda_nxt = 1'b1;
              end else begin
                phase_nxt = PH_WS; sda_nxt = shift_sh[7];
              end
            end
            PH_A1: begin phase_nxt = PH_A2; scl_nxt = 1'b1; sda_nxt = 1'b1; end
            PH_A2: begin
              phase_nxt = PH_AP; scl_nxt = 1'b1; sda_nxt = 1'b1; poll_nxt = '0;
            end
            PH_RL: begin
              shift_nxt = {shift_r[6:0], q_item.sda_in};
              phase_nxt = PH_RH; scl_nxt = 1'b1; sda_nxt = 1'b1;
            end
            PH_RH: begin
              bit_nxt = bit_inc;
              scl_nxt = 1'b0;
              if (bit_inc >= BITS_PER_BYTE) begin
                rx_nxt    = shift_r;
                phase_nxt = PH_K1; sda_nxt = !ackc_r;
              end else begin
                phase_nxt = PH_RL; sda_nxt = 1'b1;
              end
            end
            PH_K1: begin phase_nxt = PH_K2; scl_nxt = 1'b1; end
            PH_K2: begin phase_nxt = PH_IDLE; scl_nxt = 1'b0; done = 1'b1; end
            default: begin phase_nxt = PH_IDLE; done = 1'b1; end
          endcase
        end
      end
    end

    if (do_enter) begin
      wait_nxt = '0;
      unit_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= sda_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_done_r <= done;
      out_rx_r   <= rx_nxt;
      out_err_r  <= err_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = out_scl_r;
  assign out_sda_out   = out_sda_r;
  assign out_busy_res  = out_busy_r;
  assign out_done_res  = out_done_r;
  assign out_rx_byte   = out_rx_r;
  assign out_ack_error = out_err_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("done while busy");

  a_poll_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_AP |-> scl_r && sda_r)
    else $error("lines not released during ack poll");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BITS_PER_BYTE)
    else $error("bit count past byte");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(wait_r))
    else $error("engine moved without a request");

endmodule

// ===== src/i2c_master_byte_engine_top.sv =====
// Path: an accepted request is written into the queue register, then the engine
//   update loads the output register. Throughput: one request per cycle unless
//   out_stall holds the output register; each request is one tick of the bus engine.
// Reset (rst_n, synchronous, active low): unit_ticks 100, ack_timeout 250,
//   engine idle, SCL and SDA released high, queue and output register empty.
module i2c_master_byte_engine_top
  import i2cmbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_send_ack,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_ack_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] unit_ticks_r, ack_timeout_r;
  logic        wr_en;
  reg_idx_t    idx;
  cfg_t        cfg;
  logic        q_valid, q_pop;
  item_t       q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r  <= UNIT_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_UNIT_TICKS:  unit_ticks_r  <= pwdata[15:0];
        REG_ACK_TIMEOUT: ack_timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_UNIT_TICKS:  prdata = {16'd0, unit_ticks_r};
      REG_ACK_TIMEOUT: prdata = {16'd0, ack_timeout_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.unit_ticks  = TIMER_WIDTH'(unit_ticks_r);
  assign cfg.ack_timeout = ack_timeout_r;

  i2cmbe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd_valid (in_cmd_valid),
    .in_mode      (in_mode),
    .in_tx_byte   (in_tx_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  i2cmbe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_out   (out_scl_out),
    .out_sda_out   (out_sda_out),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_ack_error (out_ack_error)
  );

endmodule

// ===== test/tb_i2c_master_byte_engine_top.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine_top;
  import i2cmbe_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       err;
  } line_levels_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd_valid = 1'b0;
  logic [1:0]  in_mode = OP_START;
  logic [7:0]  in_tx_byte = 8'h00;
  logic        in_send_ack = 1'b0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_ack_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_byte_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd_valid(in_cmd_valid), .in_mode(in_mode), .in_tx_byte(in_tx_byte),
    .in_send_ack(in_send_ack), .in_sda_in(in_sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_scl_out(out_scl_out), .out_sda_out(out_sda_out),
    .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_rx_byte(out_rx_byte), .out_ack_error(out_ack_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // engine shadow state
  logic [TIMER_WIDTH-1:0] eng_unit_ticks = TIMER_WIDTH'(UNIT_TICKS_RST);
  logic [15:0]            eng_ack_timeout = ACK_TIMEOUT_RST;
  phase_t                 eng_phase = PH_IDLE;
  logic [1:0]             eng_op = OP_START;
  logic [3:0]             eng_bits = 4'd0;
  logic [TIMER_WIDTH-1:0] eng_wait = '0;
  logic [2:0]             eng_units = 3'd0;
  logic [15:0]            eng_polls = 16'd0;
  logic [7:0]             eng_shift = 8'h00;
  logic                   eng_ack = 1'b0;
  logic                   eng_scl = 1'b1;
  logic                   eng_sda = 1'b1;
  logic                   eng_err = 1'b0;
  logic [7:0]             eng_rx = 8'h00;
  logic                   eng_done = 1'b0;

  line_levels_t pending_levels[$];
  line_levels_t want, got;

  int  err_count = 0;
  int  n_ticks = 0;
  int  n_cmds[4] = '{0, 0, 0, 0};
  int  n_missed_acks = 0;
  bit  jitter_on = 1'b1;
  int  stall_request = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  ack_delay = 0;       // polls before the target pulls SDA low; -1 never
  logic [7:0] slave_byte = 8'h00;

  function automatic logic [2:0] span_units(phase_t p);
    case (p)
      PH_S1, PH_S2, PH_P1, PH_P2: return 3'd4;
      PH_WS, PH_WH, PH_WL, PH_RL, PH_K1, PH_K2: return 3'd2;
      PH_A1, PH_A2, PH_RH: return 3'd1;
      default: return 3'd0;
    endcase
  endfunction

  function automatic void go(phase_t p, logic scl, logic sda);
    eng_phase = p;
    eng_scl = scl;
    eng_sda = sda;
    eng_wait = '0;
    eng_units = 3'd0;
  endfunction

  function automatic void finish_cmd(logic scl, logic sda);
    go(PH_IDLE, scl, sda);
    eng_done = 1'b1;
  endfunction

  function automatic line_levels_t predict_bus_tick(item_t it);
    logic [TIMER_WIDTH-1:0] unit;
    line_levels_t r;
    eng_done = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (it.cmd_valid) begin
        eng_op = it.op;
        eng_bits = 4'd0;
        n_cmds[int'(it.op)]++;
        case (it.op)
          OP_START: go(PH_S1, 1'b1, 1'b1);
          OP_STOP: go(PH_P1, 1'b0, 1'b0);
          OP_WRITE: begin
            eng_err = 1'b0;
            eng_shift = it.tx_byte;
            go(PH_WS, 1'b0, it.tx_byte[7]);
          end
          default: begin
            eng_shift = 8'h00;
            eng_ack = it.send_ack;
            go(PH_RL, 1'b0, 1'b1);
          end
        endcase
      end
    end else if (eng_phase == PH_AP) begin
      if (!it.sda_in) begin
        finish_cmd(1'b0, 1'b1);
      end else if (eng_polls >= eng_ack_timeout) begin
        eng_err = 1'b1;
        n_missed_acks++;
        go(PH_P1, 1'b0, 1'b0);
      end else begin
        eng_polls = eng_polls + 16'd1;
      end
    end else begin
      unit = (eng_unit_ticks == '0) ? TIMER_WIDTH'(1) : eng_unit_ticks;
      eng_wait = eng_wait + 1'b1;
      if (eng_wait >= unit) begin
        eng_wait = '0;
        eng_units = eng_units + 3'd1;
        if (eng_units >= span_units(eng_phase)) begin
          case (eng_phase)
            PH_S1: go(PH_S2, 1'b1, 1'b0);
            PH_S2: finish_cmd(1'b0, 1'b0);
            PH_P1: go(PH_P2, 1'b1, 1'b1);
            PH_P2: finish_cmd(1'b1, 1'b1);
            PH_WS: go(PH_WH, 1'b1, eng_sda);
            PH_WH: go(PH_WL, 1'b0, eng_sda);
            PH_WL: begin
              eng_shift = {eng_shift[6:0], 1'b0};
              eng_bits = eng_bits + 4'd1;
              if (eng_bits >= BITS_PER_BYTE) go(PH_A1, 1'b0, 1'b1);
              else go(PH_WS, 1'b0, eng_shift[7]);
            end
            PH_A1: go(PH_A2, 1'b1, 1'b1);
            PH_A2: begin
              go(PH_AP, 1'b1, 1'b1);
              eng_polls = 16'd0;
            end
            PH_RL: begin
              eng_shift = {eng_shift[6:0], it.sda_in};
              go(PH_RH, 1'b1, 1'b1);
            end
            PH_RH: begin
              eng_bits = eng_bits + 4'd1;
              if (eng_bits >= BITS_PER_BYTE) begin
                eng_rx = eng_shift;
                go(PH_K1, 1'b0, !eng_ack);
              end else begin
                go(PH_RL, 1'b0, 1'b1);
              end
            end
            PH_K1: go(PH_K2, 1'b1, eng_sda);
            PH_K2: finish_cmd(1'b0, eng_sda);
            default: finish_cmd(eng_scl, eng_sda);
          endcase
        end
      end
    end
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = (eng_phase != PH_IDLE);
    r.done = eng_done;
    r.rx = eng_rx;
    r.err = eng_err;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!jitter_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one bus tick with random content; SDA follows a well-behaved target
  function automatic item_t bus_tick(bit allow_cmd);
    item_t it;
    it.cmd_valid = allow_cmd && ($urandom_range(0, 1) == 1);
    it.op = op_t'($urandom_range(0, 3));
    it.tx_byte = 8'($urandom_range(0, 255));
    it.send_ack = 1'($urandom_range(0, 1));
    case (eng_phase)
      PH_AP: it.sda_in = !(ack_delay >= 0 && eng_polls >= ack_delay);
      PH_RL: it.sda_in = slave_byte[3'd7 - eng_bits[2:0]];
      default: it.sda_in = 1'($urandom_range(0, 1));
    endcase
    return it;
  endfunction

  function automatic int ack_plan();
    if (eng_ack_timeout <= 64 && $urandom_range(0, 3) == 0) return -1;
    return $urandom_range(0, (eng_ack_timeout < 40) ? eng_ack_timeout : 40);
  endfunction

  task automatic send_tick(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd_valid <= it.cmd_valid;
    in_mode <= it.op;
    in_tx_byte <= it.tx_byte;
    in_send_ack <= it.send_ack;
    in_sda_in <= it.sda_in;
    do @(posedge clk); while (in_stall);
    pending_levels.push_back(predict_bus_tick(it));
    n_ticks++;
  endtask

  // for reads, data is what the target shifts out
  task automatic do_cmd(op_t op, logic [7:0] data, logic ack_bit, int ack_after);
    item_t it;
    ack_delay = ack_after;
    slave_byte = data;
    it = bus_tick(1'b0);
    it.cmd_valid = 1'b1;
    it.op = op;
    it.tx_byte = data;
    it.send_ack = ack_bit;
    send_tick(it);
    while (eng_phase != PH_IDLE) send_tick(bus_tick(1'b1));
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] val);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== val[15:0]) begin
      $error("register %s readback: expected %0h, got %0h", r.name(), val[15:0],
             prdata[15:0]);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    if (r == REG_UNIT_TICKS) eng_unit_ticks = TIMER_WIDTH'(val[15:0]);
    else eng_ack_timeout = val[15:0];
  endtask

  task automatic set_regs(logic [15:0] unit, logic [15:0] timeout);
    cfg_write(REG_UNIT_TICKS, {16'd0, unit});
    cfg_write(REG_ACK_TIMEOUT, {16'd0, timeout});
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_levels.size() == 0) begin
          $error("result with nothing expected");
          err_count++;
        end else begin
          want = pending_levels.pop_front();
          got = '{out_scl_out, out_sda_out, out_busy_res, out_done_res, out_rx_byte,
                  out_ack_error};
          check_field("scl_out", 8'(want.scl), 8'(got.scl));
          check_field("sda_out", 8'(want.sda), 8'(got.sda));
          check_field("busy_res", 8'(want.busy), 8'(got.busy));
          check_field("done_res", 8'(want.done), 8'(got.done));
          check_field("rx_byte", want.rx, got.rx);
          check_field("ack_error", 8'(want.err), 8'(got.err));
        end
      end
      if (stall_request > 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic test_reset_config();
    jitter_on = 1'b1;
    do_cmd(OP_START, 8'h00, 1'b0, 0);
  endtask

  task automatic test_start_stop();
    set_regs(16'd1, 16'd3);
    do_cmd(OP_START, 8'h00, 1'b0, 0);
    do_cmd(OP_STOP, 8'h00, 1'b0, 0);
    do_cmd(OP_STOP, 8'hFF, 1'b1, 0);
    set_regs(16'd2, 16'd3);
    do_cmd(OP_START, 8'h00, 1'b1, 0);
  endtask

  task automatic test_write_ack();
    set_regs(16'd1, 16'd3);
    do_cmd(OP_WRITE, 8'hFF, 1'b0, 0);
    do_cmd(OP_WRITE, 8'h00, 1'b1, 2);
    do_cmd(OP_WRITE, 8'hA5, 1'b0, 3);   // ack on the last tolerated poll
    do_cmd(OP_WRITE, 8'h5A, 1'b1, 1);
  endtask

  task automatic test_ack_failure();
    do_cmd(OP_WRITE, 8'h3C, 1'b0, -1);
    do_cmd(OP_READ, 8'h81, 1'b1, 0);    // error flag survives other commands
    do_cmd(OP_START, 8'h00, 1'b0, 0);
    set_regs(16'd1, 16'd0);
    do_cmd(OP_WRITE, 8'hC3, 1'b0, -1);
    do_cmd(OP_WRITE, 8'h7E, 1'b0, 0);
    set_regs(16'd1, 16'd1);
    do_cmd(OP_WRITE, 8'h01, 1'b1, 1);
    do_cmd(OP_WRITE, 8'h80, 1'b1, -1);
  endtask

  task automatic test_read();
    set_regs(16'd1, 16'd8);
    do_cmd(OP_READ, 8'hFF, 1'b1, 0);
    do_cmd(OP_READ, 8'h00, 1'b0, 0);
    do_cmd(OP_READ, 8'h96, 1'b1, 0);
    do_cmd(OP_READ, 8'h69, 1'b0, 0);
  endtask

  task automatic test_timing_extremes();
    cfg_write(REG_UNIT_TICKS, 32'hFFFF_0000);   // zero unit length runs as one
    do_cmd(OP_WRITE, 8'h81, 1'b0, 0);
    do_cmd(OP_READ, 8'hB7, 1'b1, 0);
    cfg_write(REG_UNIT_TICKS, 32'h0001_0002);
    do_cmd(OP_READ, 8'h4D, 1'b0, 0);
    cfg_write(REG_ACK_TIMEOUT, 32'hFFFF_FFFF);
    do_cmd(OP_WRITE, 8'h18, 1'b1, 300);
  endtask

  task automatic test_backpressure();
    set_regs(16'd1, 16'd10);
    jitter_on = 1'b0;
    stall_request = 60;
    do_cmd(OP_WRITE, 8'hC3, 1'b0, 2);
    do_cmd(OP_READ, 8'h3C, 1'b1, 0);
    jitter_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int base;
    int k;
    int n_ops;
    base = n_ticks;
    k = 0;
    while (n_ticks - base < 550) begin
      case (k % 6)
        0: set_regs(16'd1, 16'd0);
        1: set_regs(16'd1, 16'd5);
        2: set_regs(16'd2, 16'd2);
        3: set_regs(16'd1, 16'hFFFF);
        4: set_regs(16'd0, 16'd1);
        default: set_regs(16'd3, 16'd20);
      endcase
      k++;
      jitter_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        do_cmd(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
        n_ops = $urandom_range(1, 3);
        repeat (n_ops) begin
          if ($urandom_range(0, 1) == 1)
            do_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   ack_plan());
          else
            do_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
          repeat ($urandom_range(0, 3)) send_tick(bus_tick(1'b0));
        end
        do_cmd(OP_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
      end else begin
        repeat ($urandom_range(1, 3))
          do_cmd(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), ack_plan());
      end
    end
    jitter_on = 1'b1;
  endtask

  // left busy at the end: a full phase at this unit length is far too long
  task automatic test_max_unit();
    item_t it;
    set_regs(16'hFFFF, 16'hFFFF);
    it = bus_tick(1'b0);
    it.cmd_valid = 1'b1;
    it.op = OP_START;
    send_tick(it);
    repeat (300) send_tick(bus_tick(1'b1));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_start_stop();
    test_write_ack();
    test_ack_failure();
    test_read();
    test_timing_extremes();
    test_backpressure();
    test_random_traffic();
    test_max_unit();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Ran %0d bus ticks: %0d starts, %0d stops, %0d writes, %0d reads.",
             n_ticks, n_cmds[OP_START], n_cmds[OP_STOP], n_cmds[OP_WRITE], n_cmds[OP_READ]);
    $display("Missed acks: %0d; unit lengths 0..65535, ack timeouts 0..65535.",
             n_missed_acks);
    if (err_count == 0) begin
      $display("i2c_master_byte_engine_top regression: pass");
    end else begin
      $display("i2c_master_byte_engine_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding.", pending_levels.size());
    $display("i2c_master_byte_engine_top regression: fail");
    $finish;
  end

endmodule
